/* hdl/ohist_pkg.sv */
// Shared constants, widths and interface types of the overlapping block histogram.
`timescale 1ns / 1ps
package ohist_pkg;

   localparam int BINS            = 16;
   localparam int MAX_OPEN_BLOCKS = 256;
   localparam int MAX_FRAME_DIM   = 1024;

   localparam int STORE_SIZE = MAX_OPEN_BLOCKS * BINS;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int SLOT_W     = $clog2(MAX_OPEN_BLOCKS);
   localparam int BIN_W      = (BINS > 1) ? $clog2(BINS) : 1;

   localparam int DIM_W   = 11;   // frame dimension registers
   localparam int POS_W   = 10;   // row / column position
   localparam int IDX_W   = 11;   // block origin indexes and divider quotient
   localparam int BLK_W   = 7;    // block size registers
   localparam int OVL_W   = 6;    // overlap registers
   localparam int COUNT_W = 13;
   localparam int NUM_W   = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [NUM_W-1:0]   NUM_MAX   = {NUM_W{1'b1}};

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BLOCK_ROWS   = 3'd2,
      REG_BLOCK_COLS   = 3'd3,
      REG_OVERLAP_ROWS = 3'd4,
      REG_OVERLAP_COLS = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [BLK_W-1:0] block_rows;
      logic [BLK_W-1:0] block_cols;
      logic [OVL_W-1:0] overlap_rows;
      logic [OVL_W-1:0] overlap_cols;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [IDX_W-1:0] dividend;
      logic [BLK_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quotient;
      logic [BLK_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* hdl/ohist_csr.sv */
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
module ohist_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ohist_pkg::CSR_AW-1:0] paddr,
   input  logic [ohist_pkg::CSR_DW-1:0] pwdata,
   output logic [ohist_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output ohist_pkg::cfg_type         cfg
);
   import ohist_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[CSR_AW-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= DIM_W'(64);
         cfg_ff.frame_height <= DIM_W'(64);
         cfg_ff.block_rows   <= BLK_W'(8);
         cfg_ff.block_cols   <= BLK_W'(8);
         cfg_ff.overlap_rows <= '0;
         cfg_ff.overlap_cols <= '0;
      end else if (write_en) begin
         case (index)
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= pwdata[DIM_W-1:0];
            REG_BLOCK_ROWS:   cfg_ff.block_rows   <= pwdata[BLK_W-1:0];
            REG_BLOCK_COLS:   cfg_ff.block_cols   <= pwdata[BLK_W-1:0];
            REG_OVERLAP_ROWS: cfg_ff.overlap_rows <= pwdata[OVL_W-1:0];
            REG_OVERLAP_COLS: cfg_ff.overlap_cols <= pwdata[OVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FRAME_WIDTH:  prdata = CSR_DW'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = CSR_DW'(cfg_ff.frame_height);
         REG_BLOCK_ROWS:   prdata = CSR_DW'(cfg_ff.block_rows);
         REG_BLOCK_COLS:   prdata = CSR_DW'(cfg_ff.block_cols);
         REG_OVERLAP_ROWS: prdata = CSR_DW'(cfg_ff.overlap_rows);
         REG_OVERLAP_COLS: prdata = CSR_DW'(cfg_ff.overlap_cols);
         default:          prdata = '0;
      endcase
   end

endmodule

/* hdl/ohist_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ohist_div (
   input  logic                   clock,
   input  logic                   reset,
   input  ohist_pkg::div_req_type req,
   output ohist_pkg::div_rsp_type rsp
);
   import ohist_pkg::*;

   localparam int CNT_W = $clog2(IDX_W + 1);

   logic [IDX_W-1:0] work_ff;
   logic [BLK_W-1:0] rem_ff;
   logic [BLK_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [BLK_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, work_ff[IDX_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            work_ff <= req.dividend;
            den_ff  <= req.divisor;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(IDX_W);
         end else if (cnt_ff != '0) begin
            // shift in one dividend bit, subtract when it fits
            rem_ff  <= fits ? BLK_W'(shifted - {1'b0, den_ff}) : shifted[BLK_W-1:0];
            work_ff <= {work_ff[IDX_W-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = work_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* hdl/overlapping_block_histogram.sv */
// Top level of the overlapping block histogram: sequencer, count store and result register.
`timescale 1ns / 1ps
// Pixels enter on the req_ channel in raster order, one word each; req_frame_start
// marks the first pixel of a frame. Blocks of block_rows x block_cols pixels step by
// (size - overlap), at least one, and only blocks wholly inside the frame count.
// Each pixel adds one to its bin in every block covering it; at a block's
// bottom-right pixel the BINS counts go out on the rsp_ channel, one word per bin,
// last_bin on the final one, and that block's counts are cleared.
// Configuration sits behind the APB-style port (psel ... pready), to be written while
// idle; the block does not enforce this. One pixel at a time: req_stall is high from
// acceptance until the pixel is retired. Per pixel the shared serial divider (11
// quotient bits each) runs the six divisions that find the covering block range;
// each covering block then has a store read-modify-write, a counter set first
// touched in a frame is zeroed bin by bin, and each emitted bin is read and cleared
// through the single store port. A stalled rsp_ word holds and the sequencer waits
// for it before the next bin. Reset restores the register defaults, clears the
// position, the block number and the per-set valid flags at once (no clearing
// pass), and drops any pending word.
module overlapping_block_histogram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_pixel_value,
   input  logic                         req_frame_start,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_block_number,
   output logic [5:0]                   rsp_bin_number,
   output logic [12:0]                  rsp_bin_count,
   output logic                         rsp_last_bin,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ohist_pkg::CSR_AW-1:0] paddr,
   input  logic [ohist_pkg::CSR_DW-1:0] pwdata,
   output logic [ohist_pkg::CSR_DW-1:0] prdata,
   output logic                         pready
);
   import ohist_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_GO, S_DIV_WAIT, S_CALC, S_ROW, S_SLOT, S_CHK, S_CLR,
      S_RD, S_WR, S_FIN, S_FROW, S_FSLOT, S_ERD, S_EOUT, S_ADV
   } state_type;

   // order of the divisions run for each pixel
   typedef enum logic [2:0] {
      D_ROWS = 3'd0, D_COLS = 3'd1, D_RPOS = 3'd2, D_RFIN = 3'd3,
      D_CPOS = 3'd4, D_CFIN = 3'd5
   } div_sel_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   ohist_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   ohist_div u_div (.clock, .reset, .req(div_req), .rsp(div_rsp));

   // ---- effective configuration
   logic [DIM_W-1:0] w, h;
   logic [BLK_W-1:0] br, bc, sr, sc;
   logic             no_blocks;

   always_comb begin
      w  = (cfg.frame_width == '0) ? DIM_W'(1) :
           (cfg.frame_width > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : cfg.frame_width;
      h  = (cfg.frame_height == '0) ? DIM_W'(1) :
           (cfg.frame_height > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : cfg.frame_height;
      br = (cfg.block_rows == '0) ? BLK_W'(1) :
           (cfg.block_rows > BLK_W'(64)) ? BLK_W'(64) : cfg.block_rows;
      bc = (cfg.block_cols == '0) ? BLK_W'(1) :
           (cfg.block_cols > BLK_W'(64)) ? BLK_W'(64) : cfg.block_cols;
      sr = (BLK_W'(cfg.overlap_rows) < br) ? BLK_W'(br - BLK_W'(cfg.overlap_rows)) : BLK_W'(1);
      sc = (BLK_W'(cfg.overlap_cols) < bc) ? BLK_W'(bc - BLK_W'(cfg.overlap_cols)) : BLK_W'(1);
      no_blocks = (h < DIM_W'(br)) || (w < DIM_W'(bc));
   end

   // ---- sequencer registers
   state_type            state_ff;
   div_sel_type          sel_ff;
   logic [POS_W-1:0]     r_ff, c_ff;
   logic [NUM_W-1:0]     done_ff;
   logic [BIN_W-1:0]     bin_ff, k_ff;
   logic [IDX_W-1:0]     q_ff [6];
   logic [BLK_W-1:0]     rem_ff [6];
   logic [IDX_W-1:0]     i_ff, j_ff, jlo_ff, ihi_ff, jhi_ff, fi_ff, fj_ff;
   logic                 fin_ff;
   logic [SLOT_W-1:0]    base_ff, slot_ff;
   logic                 slot_valid_ff [MAX_OPEN_BLOCKS];
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [NUM_W-1:0]     rsp_num_ff;
   logic [5:0]           rsp_bin_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept, out_free;
   logic [15:0]          bin_prod;
   logic [BIN_W-1:0]     bin_in;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign bin_prod  = 16'(req_pixel_value) * 16'(BINS);
   assign bin_in    = bin_prod[8 +: BIN_W];

   // ---- divider operands
   logic [IDX_W-1:0] r1, c1, rfin_d, cfin_d;
   logic             rf_ok, cf_ok;

   always_comb begin
      r1     = IDX_W'(r_ff) + IDX_W'(1);
      c1     = IDX_W'(c_ff) + IDX_W'(1);
      rf_ok  = r1 >= IDX_W'(br);
      cf_ok  = c1 >= IDX_W'(bc);
      rfin_d = rf_ok ? IDX_W'(r1 - IDX_W'(br)) : '0;
      cfin_d = cf_ok ? IDX_W'(c1 - IDX_W'(bc)) : '0;
      div_req.start = (state_ff == S_DIV_GO);
      case (sel_ff)
         D_ROWS:  div_req.dividend = IDX_W'(h - DIM_W'(br));
         D_COLS:  div_req.dividend = IDX_W'(w - DIM_W'(bc));
         D_RPOS:  div_req.dividend = IDX_W'(r_ff);
         D_RFIN:  div_req.dividend = rfin_d;
         D_CPOS:  div_req.dividend = IDX_W'(c_ff);
         D_CFIN:  div_req.dividend = cfin_d;
         default: div_req.dividend = '0;
      endcase
      div_req.divisor = (sel_ff == D_COLS || sel_ff == D_CPOS || sel_ff == D_CFIN) ? sc : sr;
   end

   // ---- covering block range and finishing block
   logic [IDX_W-1:0] ilo, ihi, jlo, jhi, nbr_m1, nbc_m1;
   logic             fin_row, fin_col;

   always_comb begin
      nbr_m1  = q_ff[D_ROWS];
      nbc_m1  = q_ff[D_COLS];
      ilo     = rf_ok ? IDX_W'(q_ff[D_RFIN] + IDX_W'(rem_ff[D_RFIN] != '0)) : '0;
      jlo     = cf_ok ? IDX_W'(q_ff[D_CFIN] + IDX_W'(rem_ff[D_CFIN] != '0)) : '0;
      ihi     = (q_ff[D_RPOS] > nbr_m1) ? nbr_m1 : q_ff[D_RPOS];
      jhi     = (q_ff[D_CPOS] > nbc_m1) ? nbc_m1 : q_ff[D_CPOS];
      fin_row = rf_ok && (rem_ff[D_RFIN] == '0) && (q_ff[D_RFIN] <= nbr_m1);
      fin_col = cf_ok && (rem_ff[D_CFIN] == '0) && (q_ff[D_CFIN] <= nbc_m1);
   end

   // ---- counter set of block (i, j): (i * blocks_per_row + j) mod set count
   logic [2*IDX_W-1:0]        row_prod;
   logic [SLOT_W+IDX_W-1:0]   slot_sum;
   logic [SLOT_W-1:0]         base_in, slot_in;

   assign row_prod = (2*IDX_W)'(i_ff) * (2*IDX_W)'(nbc_m1 + IDX_W'(1));
   assign base_in  = row_prod[SLOT_W-1:0];
   assign slot_sum = (SLOT_W+IDX_W)'(base_ff) + (SLOT_W+IDX_W)'(j_ff);
   assign slot_in  = slot_sum[SLOT_W-1:0];

   // ---- count store
   logic [COUNT_W-1:0] store [STORE_SIZE];
   logic [COUNT_W-1:0] q_rd_ff, wdata, q_inc;
   logic [ADDR_W-1:0]  addr;
   logic [BIN_W-1:0]   addr_bin;
   logic               we, re;

   always_comb begin
      addr_bin = (state_ff == S_RD || state_ff == S_WR) ? bin_ff : k_ff;
      addr     = ADDR_W'(ADDR_W'(slot_ff) * ADDR_W'(BINS) + ADDR_W'(addr_bin));
      q_inc    = (q_rd_ff < COUNT_MAX) ? COUNT_W'(q_rd_ff + 1'b1) : q_rd_ff;
      wdata    = (state_ff == S_WR) ? q_inc : '0;
      we       = (state_ff == S_CLR) || (state_ff == S_WR) ||
                 ((state_ff == S_EOUT) && out_free);
      re       = (state_ff == S_RD) || (state_ff == S_ERD);
   end

   always_ff @(posedge clock) begin
      if (we) store[addr] <= wdata;
      if (re) q_rd_ff <= store[addr];
   end

   // ---- position after this pixel
   logic [IDX_W-1:0] r_next;
   logic             row_wrap, frame_wrap;

   assign row_wrap   = c1 >= IDX_W'(w);
   assign r_next     = row_wrap ? r1 : IDX_W'(r_ff);
   assign frame_wrap = r_next >= IDX_W'(h);

   // ---- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= D_ROWS;
         r_ff         <= '0;
         c_ff         <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_OPEN_BLOCKS; s++) slot_valid_ff[s] <= 1'b0;
      end else begin
         // drop the result word once taken, unless the next one loads now
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EOUT) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  bin_ff <= bin_in;
                  sel_ff <= D_ROWS;
                  if (req_frame_start) begin
                     r_ff    <= '0;
                     c_ff    <= '0;
                     done_ff <= '0;
                     for (int s = 0; s < MAX_OPEN_BLOCKS; s++) slot_valid_ff[s] <= 1'b0;
                  end
                  state_ff <= no_blocks ? S_ADV : S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  q_ff[sel_ff]   <= div_rsp.quotient;
                  rem_ff[sel_ff] <= div_rsp.remainder;
                  if (sel_ff == D_CFIN) begin
                     state_ff <= S_CALC;
                  end else begin
                     sel_ff   <= div_sel_type'(sel_ff + 3'd1);
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            S_CALC: begin
               fin_ff <= fin_row && fin_col;
               fi_ff  <= q_ff[D_RFIN];
               fj_ff  <= q_ff[D_CFIN];
               i_ff   <= ilo;
               jlo_ff <= jlo;
               ihi_ff <= ihi;
               jhi_ff <= jhi;
               state_ff <= (ilo <= ihi && jlo <= jhi) ? S_ROW : S_FIN;
            end
            S_ROW: begin
               base_ff  <= base_in;
               j_ff     <= jlo_ff;
               state_ff <= S_SLOT;
            end
            S_SLOT: begin
               slot_ff  <= slot_in;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               // first touch of a set in this frame: zero its counts
               k_ff     <= '0;
               state_ff <= slot_valid_ff[slot_ff] ? S_RD : S_CLR;
            end
            S_CLR: begin
               if (k_ff == BIN_W'(BINS - 1)) begin
                  slot_valid_ff[slot_ff] <= 1'b1;
                  state_ff <= S_RD;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               if (j_ff == jhi_ff) begin
                  if (i_ff == ihi_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_ROW;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_SLOT;
               end
            end
            S_FIN: begin
               i_ff     <= fi_ff;
               j_ff     <= fj_ff;
               state_ff <= fin_ff ? S_FROW : S_ADV;
            end
            S_FROW: begin
               base_ff  <= base_in;
               state_ff <= S_FSLOT;
            end
            S_FSLOT: begin
               slot_ff  <= slot_in;
               k_ff     <= '0;
               state_ff <= S_ERD;
            end
            S_ERD: state_ff <= S_EOUT;
            S_EOUT: begin
               // hold until the result register is free, then clear the bin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_num_ff   <= done_ff;
                  rsp_bin_ff   <= 6'(k_ff);
                  rsp_count_ff <= slot_valid_ff[slot_ff] ? q_rd_ff : '0;
                  rsp_last_ff  <= (k_ff == BIN_W'(BINS - 1));
                  if (k_ff == BIN_W'(BINS - 1)) begin
                     if (done_ff != NUM_MAX) done_ff <= done_ff + 1'b1;
                     state_ff <= S_ADV;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_ERD;
                  end
               end
            end
            S_ADV: begin
               if (frame_wrap) begin
                  r_ff    <= '0;
                  c_ff    <= '0;
                  done_ff <= '0;
                  for (int s = 0; s < MAX_OPEN_BLOCKS; s++) slot_valid_ff[s] <= 1'b0;
               end else begin
                  r_ff <= r_next[POS_W-1:0];
                  c_ff <= row_wrap ? '0 : c1[POS_W-1:0];
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_num_ff;
   assign rsp_bin_number   = rsp_bin_ff;
   assign rsp_bin_count    = rsp_count_ff;
   assign rsp_last_bin     = rsp_last_ff;

endmodule

/* verif/block_histogram_checker.sv */
// Watches the pixel, result and register ports and checks every histogram word.
`timescale 1ns / 1ps
module block_histogram_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_pixel_value,
   input  logic                          req_frame_start,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [15:0]                   rsp_block_number,
   input  logic [5:0]                    rsp_bin_number,
   input  logic [12:0]                   rsp_bin_count,
   input  logic                          rsp_last_bin,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ohist_pkg::CSR_AW-1:0]  paddr,
   input  logic [ohist_pkg::CSR_DW-1:0]  pwdata,
   input  logic                          pready,
   output int                            error_count,
   output int                            words_pending,
   output int                            words_checked
);
   import ohist_pkg::*;

   typedef struct {
      int block_num;
      int bin_num;
      int count;
      bit last;
   } bin_word_type;

   bin_word_type expected_bins[$];
   int        bin_counts[STORE_SIZE];
   int        row_pos, col_pos, blocks_done;
   int        frame_w, frame_h, blk_rows, blk_cols, ovl_rows, ovl_cols;

   initial begin
      error_count   = 0;
      words_pending = 0;
      words_checked = 0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void clear_frame();
      foreach (bin_counts[k]) bin_counts[k] = 0;
      row_pos     = 0;
      col_pos     = 0;
      blocks_done = 0;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int origins(int dim, int blk, int step);
      return dim < blk ? 0 : (dim - blk) / step + 1;
   endfunction

   // Add one pixel to every covering block; queue the histogram of a finished block.
   function automatic void tally_pixel(int pix, bit fs);
      int           w, h, br, bc, sr, sc, nbr, nbc, bin, r, c;
      int           ilo, ihi, jlo, jhi, slot, a;
      bin_word_type word;
      w   = clamp(frame_w, 1, MAX_FRAME_DIM);
      h   = clamp(frame_h, 1, MAX_FRAME_DIM);
      br  = clamp(blk_rows, 1, 64);
      bc  = clamp(blk_cols, 1, 64);
      sr  = ovl_rows < br ? br - ovl_rows : 1;
      sc  = ovl_cols < bc ? bc - ovl_cols : 1;
      nbr = origins(h, br, sr);
      nbc = origins(w, bc, sc);
      bin = (pix * BINS) >> 8;
      if (fs) clear_frame();
      r = row_pos;
      c = col_pos;
      if (nbr > 0 && nbc > 0) begin
         ilo = r >= br ? (r - br + sr) / sr : 0;
         ihi = r / sr;
         if (ihi > nbr - 1) ihi = nbr - 1;
         jlo = c >= bc ? (c - bc + sc) / sc : 0;
         jhi = c / sc;
         if (jhi > nbc - 1) jhi = nbc - 1;
         for (int i = ilo; i <= ihi; i++) begin
            for (int j = jlo; j <= jhi; j++) begin
               a = ((i * nbc + j) % MAX_OPEN_BLOCKS) * BINS + bin;
               if (bin_counts[a] < COUNT_MAX) bin_counts[a]++;
            end
         end
         if (r + 1 >= br && (r + 1 - br) % sr == 0 && c + 1 >= bc && (c + 1 - bc) % sc == 0
             && (r + 1 - br) / sr < nbr && (c + 1 - bc) / sc < nbc) begin
            slot = (((r + 1 - br) / sr) * nbc + (c + 1 - bc) / sc) % MAX_OPEN_BLOCKS;
            for (int k = 0; k < BINS; k++) begin
               word.block_num = blocks_done;
               word.bin_num   = k;
               word.count     = bin_counts[slot * BINS + k];
               word.last      = (k == BINS - 1);
               expected_bins.push_back(word);
               bin_counts[slot * BINS + k] = 0;
            end
            if (blocks_done < NUM_MAX) blocks_done++;
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) begin
         clear_frame();
      end else begin
         row_pos = r;
         col_pos = c;
      end
   endfunction

   always @(posedge clock) begin
      bin_word_type want;
      if (reset) begin
         frame_w  = 64;
         frame_h  = 64;
         blk_rows = 8;
         blk_cols = 8;
         ovl_rows = 0;
         ovl_cols = 0;
         clear_frame();
         expected_bins.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_AW-1:2]))
               REG_FRAME_WIDTH:  frame_w  = pwdata[DIM_W-1:0];
               REG_FRAME_HEIGHT: frame_h  = pwdata[DIM_W-1:0];
               REG_BLOCK_ROWS:   blk_rows = pwdata[BLK_W-1:0];
               REG_BLOCK_COLS:   blk_cols = pwdata[BLK_W-1:0];
               REG_OVERLAP_ROWS: ovl_rows = pwdata[OVL_W-1:0];
               REG_OVERLAP_COLS: ovl_cols = pwdata[OVL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) tally_pixel(req_pixel_value, req_frame_start);
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (expected_bins.size() == 0) begin
               report_mismatch("word with none expected, block", rsp_block_number, -1);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_block_number != want.block_num)
                  report_mismatch("block_number", rsp_block_number, want.block_num);
               if (rsp_bin_number != want.bin_num)
                  report_mismatch("bin_number", rsp_bin_number, want.bin_num);
               if (rsp_bin_count != want.count)
                  report_mismatch("bin_count", rsp_bin_count, want.count);
               if (rsp_last_bin != want.last)
                  report_mismatch("last_bin", rsp_last_bin, want.last);
            end
         end
      end
      words_pending = expected_bins.size();
   end

endmodule

/* verif/overlapping_block_histogram_tb.sv */
// Top of the overlapping block histogram testbench: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module overlapping_block_histogram_tb;
   import ohist_pkg::*;

   // Cycles to let a pixel that yields no word finish before touching registers.
   localparam int SETTLE = 800;

   logic                clock;
   logic                reset;
   logic                req_valid, req_stall;
   logic [7:0]          req_pixel_value;
   logic                req_frame_start;
   logic                rsp_valid, rsp_stall;
   logic [15:0]         rsp_block_number;
   logic [5:0]          rsp_bin_number;
   logic [12:0]         rsp_bin_count;
   logic                rsp_last_bin;
   logic                psel, penable, pwrite, pready;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata, prdata;

   int error_count, words_pending, words_checked;
   int idle_pct, stall_pct;
   int pixels_sent;

   overlapping_block_histogram u_dut (.*);

   block_histogram_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs or a word never shows up.
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Receiver side: stall at the rate of the current idling phase.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Pick an idling phase: none, sender idle, receiver stalling, or both a little.
   task automatic set_mode(int m);
      case (m)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 79; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 79; end
         default: begin idle_pct = 15; stall_pct = 15; end
      endcase
   endtask

   // Drop valid and hold until every expected word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(int w, int h, int br, int bc, int ovr, int ovc);
      drain();
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_BLOCK_ROWS, br);
      write_reg(REG_BLOCK_COLS, bc);
      write_reg(REG_OVERLAP_ROWS, ovr);
      write_reg(REG_OVERLAP_COLS, ovc);
   endtask

   // Present one pixel word, idling first at random, and hold it until accepted.
   task automatic send_pixel(logic [7:0] pix, logic fs);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // Random pixels; frame starts are sprinkled in as noise at fs_pct percent.
   task automatic send_random(int n, int fs_pct, int mode_base);
      for (int k = 0; k < n; k++) begin
         if (k % 25 == 0) set_mode((mode_base + k / 25) % 4);
         send_pixel(8'($urandom_range(255)), $urandom_range(99) < fs_pct);
      end
   endtask

   initial begin
      logic [7:0] edge_pixels[20];
      edge_pixels = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd15, 8'd16, 8'd239, 8'd240, 8'd127,
                      8'd128, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'd31, 8'd32, 8'd200, 8'd100,
                      8'd64, 8'd192};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel_value <= '0;
      req_frame_start <= 1'b0;
      rsp_stall       <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      pixels_sent     = 0;
      set_mode(0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: bin edges and pixel extremes, too few pixels to finish a block.
      foreach (edge_pixels[k]) send_pixel(edge_pixels[k], k == 0);

      // Small 2x2 tiling of a 4x4 frame: one full frame, a full pause, then noise.
      configure(4, 4, 2, 2, 0, 0);
      set_mode(2);
      for (int k = 0; k < 16; k++) send_pixel(8'($urandom_range(255)), k == 0);
      drain();
      send_random(40, 10, 1);

      // Overlap not smaller than the block: row step clamps to one; columns step two.
      configure(5, 3, 3, 3, 63, 1);
      send_pixel(8'($urandom_range(255)), 1'b1);
      send_random(30, 5, 2);

      // Shrink the frame mid-frame: the old position may now be outside it.
      configure(3, 3, 2, 2, 1, 0);
      send_random(20, 0, 3);

      // Block larger than the frame: nothing comes out.
      configure(2, 2, 64, 64, 0, 0);
      send_random(10, 20, 0);

      // Zero and all-ones register values clamp: 1x1 blocks, every pixel finishes one.
      configure(0, 2047, 0, 0, 63, 63);
      send_random(12, 10, 1);

      // Tall overlapping blocks: walk 32 rows on a one-pixel-wide frame, then widen it
      // to 8 so that 264 blocks exist and blocks 32 block rows apart share counter sets.
      configure(1, 65, 33, 1, 32, 0);
      send_pixel(8'($urandom_range(255)), 1'b1);
      send_random(31, 0, 2);
      configure(8, 65, 33, 1, 32, 0);
      send_random(24, 0, 3);

      // Largest frame and block.
      configure(1024, 1024, 64, 64, 0, 0);
      send_pixel(8'($urandom_range(255)), 1'b1);
      send_random(10, 0, 3);

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d pixel words over nine register setups, checked %0d histogram words.",
               pixels_sent, words_checked);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* overlapping_block_histogram.f */
hdl/ohist_pkg.sv
hdl/ohist_csr.sv
hdl/ohist_div.sv
hdl/overlapping_block_histogram.sv
verif/block_histogram_checker.sv
verif/overlapping_block_histogram_tb.sv
